// File: rtl/text_console_cell_writer_defines.svh
// Assertion macros for the text console cell writer.
// Each expects clk and rst in scope; checks are off while rst is high.
`ifndef TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH

// Same-cycle implication.
`define TCCW_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCCW_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

  localparam int CHAR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 6;
  localparam int MAX_COLS = 1 << COL_W;
  localparam int MAX_ROWS = 1 << ROW_W;

  localparam logic [COL_W-1:0] RESET_COLS = COL_W'(80);
  localparam logic [ROW_W-1:0] RESET_ROWS = ROW_W'(25);
  localparam logic [COL_W:0]   TAB_STEP   = (COL_W+1)'(4);

  // control characters
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  typedef enum logic [1:0] {
    MODE_PUT_CURSOR = 2'd0,
    MODE_PUT_AT     = 2'd1,
    MODE_CLEAR_ROW  = 2'd2,
    MODE_READ       = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    CFG_SCREEN_COLS = 1'b0,
    CFG_SCREEN_ROWS = 1'b1
  } cfg_reg_t;

  localparam int CFG_W = COL_W;

  typedef enum logic [1:0] {
    ST_WRITE = 2'd0,
    ST_CLEAR = 2'd1,
    ST_READ  = 2'd2
  } store_op_t;

  // one access to the cell store; row is the physical (ring) row
  typedef struct packed {
    logic              en;
    store_op_t         op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] data;
    logic [COL_W-1:0]  cols;
  } store_req_t;

  function automatic logic is_printable(input logic [CHAR_W-1:0] ch);
    return !(ch inside {CH_NUL, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR});
  endfunction

endpackage

`default_nettype wire

// File: rtl/text_console_cell_writer.sv
// Channel   | Dir | Payload                                              | Transaction
// s_axis    | in  | tuser: mode; tdata: char_code, target_col, target_row | tvalid & tready
// m_axis    | out | tuser: draw_valid, row_cleared; tdata: draw_char,     | tvalid & tready
//           |     |   draw_col, draw_row, scroll_lines, cursor_col,      |
//           |     |   cursor_row                                         |
// cfg       | in  | cfg_index, cfg_data                                  | cfg_we
//
// Throughput: one transaction per cycle unless m_tready stalls the output; each item sees
// the cell store at most once (one row access). Path: input reg, store access, output reg.
// Reset clears cursor, ring top line, row valid bits and sizes to 80 x 25; no clearing pass.
// Stalls: each stage moves when the stage after it is empty or moving, so bubbles fill.
`default_nettype none

`include "text_console_cell_writer_defines.svh"

module text_console_cell_writer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // slave side
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [23:0]                         s_tdata,  // char_code, target_col, target_row
  input  wire logic [1:0]                          s_tuser,  // mode
  // master side
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [39:0]                              m_tdata,  // draw_char, draw_col, draw_row,
                                                             // scroll_lines, cursor_col, cursor_row
  output logic [1:0]                               m_tuser,  // draw_valid, row_cleared
  // configuration
  input  wire logic                                cfg_we,
  input  wire tccw_pkg::cfg_reg_t                  cfg_index,
  input  wire logic [tccw_pkg::CFG_W-1:0]          cfg_data
);
  import tccw_pkg::*;

  // ---- configuration and console state ----
  logic [COL_W-1:0] screen_cols;
  logic [ROW_W-1:0] screen_rows;
  logic [COL_W-1:0] cur_col, cur_col_next;
  logic [ROW_W-1:0] cur_row, cur_row_next;
  logic [ROW_W-1:0] top_line, top_line_next;

  // ---- stage 1: input register ----
  logic              s1_v;
  mode_t             s1_mode;
  logic [CHAR_W-1:0] s1_char;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;

  // ---- stage 2: result minus read data ----
  logic              s2_v;
  logic              s2_is_read;
  logic              s2_dv;
  logic [CHAR_W-1:0] s2_dc;
  logic [COL_W-1:0]  s2_dcol;
  logic [ROW_W-1:0]  s2_drow;
  logic              s2_clr;
  logic [ROW_W-1:0]  s2_scr;
  logic [COL_W-1:0]  s2_ccol;
  logic [ROW_W-1:0]  s2_crow;

  // ---- output register ----
  logic              out_v;

  logic ready_out, ready_s2, fire;

  assign ready_out = !out_v || m_tready;
  assign ready_s2  = !s2_v || ready_out;
  assign s_tready  = !s1_v || ready_s2;
  assign fire      = s1_v && ready_s2;

  // ---- item logic ----
  logic              put;
  logic [COL_W-1:0]  px;
  logic [ROW_W-1:0]  py;
  logic              printable;
  logic              clr_ok;
  logic [COL_W:0]    x;
  logic [ROW_W:0]    y;
  logic [ROW_W:0]    n;
  logic [ROW_W-1:0]  scr_next;
  store_req_t        req;
  logic [CHAR_W-1:0] rd_char;

  // stage 2 next values
  logic              s2_dv_next;
  logic [CHAR_W-1:0] s2_dc_next;
  logic [COL_W-1:0]  s2_dcol_next;
  logic [ROW_W-1:0]  s2_drow_next;
  logic              s2_clr_next;
  logic [ROW_W-1:0]  s2_scr_next;
  logic [COL_W-1:0]  s2_ccol_next;
  logic [ROW_W-1:0]  s2_crow_next;

  always_comb begin
    put       = (s1_mode == MODE_PUT_CURSOR) || (s1_mode == MODE_PUT_AT);
    px        = (s1_mode == MODE_PUT_CURSOR) ? cur_col : s1_col;
    py        = (s1_mode == MODE_PUT_CURSOR) ? cur_row : s1_row;
    printable = is_printable(s1_char);
    clr_ok    = s1_row < screen_rows;

    // cursor move for a mode-0 character
    x             = {1'b0, cur_col};
    y             = {1'b0, cur_row};
    n             = '0;
    top_line_next = top_line;
    if (s1_char != CH_NUL) begin
      case (s1_char)
        CH_LF: begin
          x = '0;
          y = y + 1'b1;
        end
        CH_TAB:        x = x + TAB_STEP;
        CH_VT, CH_FF:  y = y + 1'b1;
        CH_CR:         x = '0;
        default:       x = x + 1'b1;
      endcase
      if (x >= {1'b0, screen_cols}) begin
        x = '0;
        y = y + 1'b1;
      end
      if (screen_rows == '0) begin
        y = '0;
      end else if (y >= {1'b0, screen_rows}) begin
        // overflow past the last row scrolls the ring
        n             = y - ({1'b0, screen_rows} - 1'b1);
        top_line_next = top_line + n[ROW_W-1:0];
        y             = {1'b0, screen_rows - 1'b1};
      end
    end
    cur_col_next = x[COL_W-1:0];
    cur_row_next = y[ROW_W-1:0];
    scr_next     = n[ROW_W] ? '1 : n[ROW_W-1:0];

    // store access
    req      = '0;
    req.cols = screen_cols;
    req.col  = px;
    req.data = s1_char;
    req.row  = top_line + py;
    case (s1_mode)
      MODE_PUT_CURSOR, MODE_PUT_AT: begin
        req.en = fire && printable;
        req.op = ST_WRITE;
      end
      MODE_CLEAR_ROW: begin
        req.en   = fire && clr_ok;
        req.op   = ST_CLEAR;
        req.data = '0;
        req.row  = top_line + s1_row;
      end
      default: begin
        req.en  = fire;
        req.op  = ST_READ;
        req.col = s1_col;
        req.row = top_line + s1_row;
      end
    endcase
  end

  // result fields other than the read data
  always_comb begin
    s2_dv_next   = put && printable;
    s2_dc_next   = (put && printable) ? s1_char : '0;
    s2_dcol_next = '0;
    s2_drow_next = '0;
    s2_clr_next  = 1'b0;
    s2_scr_next  = '0;
    s2_ccol_next = cur_col;
    s2_crow_next = cur_row;
    case (s1_mode)
      MODE_PUT_CURSOR, MODE_PUT_AT: begin
        if (printable) begin
          s2_dcol_next = px;
          s2_drow_next = py;
        end
        if (s1_mode == MODE_PUT_CURSOR) begin
          s2_scr_next  = scr_next;
          s2_ccol_next = cur_col_next;
          s2_crow_next = cur_row_next;
        end
      end
      MODE_CLEAR_ROW: begin
        if (clr_ok) begin
          s2_clr_next  = 1'b1;
          s2_drow_next = s1_row;
        end
      end
      default: begin
        s2_dcol_next = s1_col;
        s2_drow_next = s1_row;
      end
    endcase
  end

  tccw_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_char (rd_char)
  );

  // ---- configuration and cursor registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_cols <= RESET_COLS;
      screen_rows <= RESET_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_COLS: screen_cols <= cfg_data;
        CFG_SCREEN_ROWS: screen_rows <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= '0;
      cur_row  <= '0;
      top_line <= '0;
    end else if (fire && s1_mode == MODE_PUT_CURSOR) begin
      cur_col  <= cur_col_next;
      cur_row  <= cur_row_next;
      top_line <= top_line_next;
    end
  end

  // ---- pipeline valids ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (s_tready)  s1_v  <= s_tvalid;
      if (ready_s2)  s2_v  <= s1_v;
      if (ready_out) out_v <= s2_v;
    end
  end

  // ---- pipeline payload ----
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_mode <= mode_t'(s_tuser);
      s1_char <= s_tdata[7:0];
      s1_col  <= s_tdata[14:8];
      s1_row  <= s_tdata[20:15];
    end
    if (fire) begin
      s2_is_read <= s1_mode == MODE_READ;
      s2_dv      <= s2_dv_next;
      s2_dc      <= s2_dc_next;
      s2_dcol    <= s2_dcol_next;
      s2_drow    <= s2_drow_next;
      s2_clr     <= s2_clr_next;
      s2_scr     <= s2_scr_next;
      s2_ccol    <= s2_ccol_next;
      s2_crow    <= s2_crow_next;
    end
    if (ready_out && s2_v) begin
      m_tuser <= {s2_clr, s2_dv};
      m_tdata <= {s2_crow, s2_ccol, s2_scr, s2_drow, s2_dcol,
                  s2_is_read ? rd_char : s2_dc};
    end
  end

  assign m_tvalid = out_v;

  // ---- checks ----
  `TCCW_CHECK_NEXT(a_cursor_in_screen,
    fire && s1_mode == MODE_PUT_CURSOR && s1_char != CH_NUL && screen_rows != '0 && !cfg_we,
    cur_row < screen_rows, "cursor row left the visible area")
  `TCCW_CHECK_NEXT(a_scroll_parks_cursor,
    fire && s1_mode == MODE_PUT_CURSOR && n != '0 && !cfg_we,
    cur_row == screen_rows - 1'b1, "scroll did not leave cursor on last row")
  `TCCW_CHECK_NEXT(a_top_line_still,
    fire && !(s1_mode == MODE_PUT_CURSOR && n != '0),
    $stable(top_line), "top line moved without a scroll")
  `TCCW_CHECK(a_draw_or_clear,
    m_tvalid, !(m_tuser[0] && m_tuser[1]), "draw and clear flagged together")

endmodule

`default_nettype wire

// File: rtl/tccw_store.sv
`default_nettype none

module tccw_store (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tccw_pkg::store_req_t        req,
  output logic [tccw_pkg::CHAR_W-1:0]      rd_char
);
  import tccw_pkg::*;

  // one memory row per physical screen row, one byte lane per column
  logic [MAX_COLS-1:0][CHAR_W-1:0] mem [MAX_ROWS];
  // a row not yet written reads as all zero
  logic [MAX_ROWS-1:0]             row_valid;

  logic [MAX_COLS-1:0]             lane_we;
  logic [MAX_COLS-1:0][CHAR_W-1:0] lane_wd;

  logic [MAX_COLS-1:0][CHAR_W-1:0] rd_row;
  logic                            rd_valid;
  logic [COL_W-1:0]                rd_col;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      lane_wd[c] = (COL_W'(c) == req.col) ? req.data : '0;
      case (req.op)
        ST_WRITE: lane_we[c] = !row_valid[req.row] || (COL_W'(c) == req.col);
        ST_CLEAR: lane_we[c] = row_valid[req.row] && (COL_W'(c) < req.cols);
        default:  lane_we[c] = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.en && req.op != ST_READ) begin
      for (int c = 0; c < MAX_COLS; c++) begin
        if (lane_we[c]) begin
          mem[req.row][c] <= lane_wd[c];
        end
      end
    end
    if (req.en && req.op == ST_READ) begin
      rd_row   <= mem[req.row];
      rd_valid <= row_valid[req.row];
      rd_col   <= req.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (req.en && req.op == ST_WRITE) begin
      row_valid[req.row] <= 1'b1;
    end
  end

  assign rd_char = rd_valid ? rd_row[rd_col] : '0;

endmodule

`default_nettype wire

// File: sim/tccw_result_checker.sv
`timescale 1ns / 100ps

// Watches the console's input, output and size-write channels. Keeps its own
// copy of the cell store, cursor and scroll state, predicts one result per
// input transaction and compares results in order.
module tccw_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [23:0]                   s_tdata,  // char_code, target_col, target_row
  input  logic [1:0]                    s_tuser,  // mode
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [39:0]                   m_tdata,  // draw_char, draw_col, draw_row,
                                                  // scroll_lines, cursor_col, cursor_row
  input  logic [1:0]                    m_tuser,  // draw_valid, row_cleared
  input  logic                          cfg_we,
  input  tccw_pkg::cfg_reg_t            cfg_index,
  input  logic [tccw_pkg::CFG_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            results_owed
);
  import tccw_pkg::*;

  // same bit order as {m_tuser[1], m_tuser[0], m_tdata}
  typedef struct packed {
    logic              row_cleared;
    logic              draw_valid;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  scroll_lines;
    logic [ROW_W-1:0]  draw_row;
    logic [COL_W-1:0]  draw_col;
    logic [CHAR_W-1:0] draw_char;
  } cell_result_t;

  cell_result_t      owed_q[$];
  logic [CHAR_W-1:0] cell_mem [MAX_COLS*MAX_ROWS];
  int                ring_top;
  int                cur_x;
  int                cur_y;
  int                vis_cols;
  int                vis_rows;

  function automatic int cell_index(int col, int row);
    return (col % MAX_COLS) + ((ring_top + row) % MAX_ROWS) * MAX_COLS;
  endfunction

  function automatic bit is_control(logic [CHAR_W-1:0] ch);
    case (ch)
      CH_NUL, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // cursor move after a put-at-cursor; returns rows scrolled
  function automatic int step_cursor(logic [CHAR_W-1:0] ch);
    int x;
    int y;
    int n;
    x = cur_x;
    y = cur_y;
    n = 0;
    if (ch == CH_NUL) return 0;
    case (ch)
      CH_LF: begin
        x = 0;
        y++;
      end
      CH_TAB:       x += int'(TAB_STEP);
      CH_VT, CH_FF: y++;
      CH_CR:        x = 0;
      default:      x++;
    endcase
    if (x >= vis_cols) begin
      x = 0;
      y++;
    end
    if (vis_rows == 0) begin
      y = 0;
    end else if (y >= vis_rows) begin
      n = y - (vis_rows - 1);
      ring_top = (ring_top + n) % MAX_ROWS;
      y = vis_rows - 1;
    end
    cur_x = x % MAX_COLS;
    cur_y = y % MAX_ROWS;
    return n;
  endfunction

  function automatic cell_result_t apply_item(mode_t mode, logic [CHAR_W-1:0] ch,
                                              logic [COL_W-1:0] tcol, logic [ROW_W-1:0] trow);
    cell_result_t r;
    int           px;
    int           py;
    int           n;
    r = '0;
    case (mode)
      MODE_PUT_CURSOR, MODE_PUT_AT: begin
        px = (mode == MODE_PUT_CURSOR) ? cur_x : int'(tcol);
        py = (mode == MODE_PUT_CURSOR) ? cur_y : int'(trow);
        if (!is_control(ch)) begin
          cell_mem[cell_index(px, py)] = ch;
          r.draw_valid = 1'b1;
          r.draw_char  = ch;
          r.draw_col   = COL_W'(px);
          r.draw_row   = ROW_W'(py);
        end
        if (mode == MODE_PUT_CURSOR) begin
          n = step_cursor(ch);
          r.scroll_lines = ROW_W'((n > MAX_ROWS - 1) ? MAX_ROWS - 1 : n);
        end
      end
      MODE_CLEAR_ROW: begin
        // rows at or past the visible height are left alone
        if (int'(trow) < vis_rows) begin
          for (int i = 0; i < vis_cols; i++) cell_mem[cell_index(i, int'(trow))] = '0;
          r.row_cleared = 1'b1;
          r.draw_row    = trow;
        end
      end
      default: begin
        r.draw_char = cell_mem[cell_index(int'(tcol), int'(trow))];
        r.draw_col  = tcol;
        r.draw_row  = trow;
      end
    endcase
    r.cursor_col = COL_W'(cur_x);
    r.cursor_row = ROW_W'(cur_y);
    return r;
  endfunction

  function automatic int field_diff(string name, int want, int got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    cell_result_t got;
    cell_result_t want;
    if (rst) begin
      foreach (cell_mem[i]) cell_mem[i] = '0;
      ring_top   = 0;
      cur_x      = 0;
      cur_y      = 0;
      vis_cols   = int'(RESET_COLS);
      vis_rows   = int'(RESET_ROWS);
      fail_count = 0;
      owed_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser[1], m_tuser[0], m_tdata};
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %h", $time, got);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          fail_count += field_diff("draw_valid", int'(want.draw_valid),
                                   int'(got.draw_valid));
          fail_count += field_diff("draw_char", int'(want.draw_char), int'(got.draw_char));
          fail_count += field_diff("draw_col", int'(want.draw_col), int'(got.draw_col));
          fail_count += field_diff("draw_row", int'(want.draw_row), int'(got.draw_row));
          fail_count += field_diff("row_cleared", int'(want.row_cleared),
                                   int'(got.row_cleared));
          fail_count += field_diff("scroll_lines", int'(want.scroll_lines),
                                   int'(got.scroll_lines));
          fail_count += field_diff("cursor_col", int'(want.cursor_col),
                                   int'(got.cursor_col));
          fail_count += field_diff("cursor_row", int'(want.cursor_row),
                                   int'(got.cursor_row));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_COLS: vis_cols = int'(cfg_data[COL_W-1:0]);
          default:         vis_rows = int'(cfg_data[ROW_W-1:0]);
        endcase
      end
      if (s_tvalid && s_tready)
        owed_q.push_back(apply_item(mode_t'(s_tuser), s_tdata[7:0], s_tdata[14:8],
                                    s_tdata[20:15]));
    end
    results_owed = owed_q.size();
  end

endmodule

// File: sim/tb_text_console_cell_writer.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the text console cell writer.
// A short directed run at the reset size covers every control character,
// each mode, writes and reads outside the visible area and clears at and
// beyond the last row. Then ten phases, each at its own screen size
// (zero width, zero height, full size, one row after a tall screen to force
// a large scroll, random sizes), run random text lines, positioned writes,
// clears, reads and some noise. The checker alongside does all prediction.
module tb_text_console_cell_writer;
  import tccw_pkg::*;

  localparam int LONG_HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_ITEMS     = 850;
  localparam int PHASES           = 10;
  localparam int MAX_WAIT         = 14;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [23:0]      s_tdata;   // char_code [7:0], target_col [14:8], target_row [20:15]
  logic [1:0]       s_tuser;   // mode
  logic             m_tvalid;
  logic             m_tready;
  logic [39:0]      m_tdata;   // draw_char, draw_col, draw_row, scroll_lines,
                               // cursor_col, cursor_row
  logic [1:0]       m_tuser;   // draw_valid, row_cleared
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int fail_count;
  int results_owed;
  int cycle_count;
  int items_sent;
  int holds_asked;
  int holds_done;
  int scr_cols;     // size as last written, for aiming coordinates
  int scr_rows;
  bit tx_idle;
  bit rx_idle;

  text_console_cell_writer dut (.*);

  tccw_result_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stall before each transaction while rx_idle is set, plus one long hold-off
  // whenever the stimulus asks for it so the pipeline backs up into s_tready.
  initial begin
    int stall;
    m_tready   = 1'b0;
    holds_done = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        m_tready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else if (rx_idle) begin
        stall = $urandom_range(0, MAX_WAIT);
        if (stall > 0) begin
          m_tready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // one input transaction; tvalid stays high back to back when there is no gap
  task automatic send_item(mode_t mode, logic [7:0] ch, logic [6:0] col, logic [5:0] row);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  = mode;
    s_tdata  = {3'b000, row, col, ch};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering and wait for every owed result
  task automatic wait_console_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic write_size(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_SCREEN_COLS) scr_cols = int'(val[COL_W-1:0]);
    else                        scr_rows = int'(val[ROW_W-1:0]);
  endtask

  // mostly inside the visible area, sometimes anywhere in the store
  function automatic logic [6:0] pick_col();
    if (scr_cols == 0 || $urandom_range(0, 4) == 0)
      return COL_W'($urandom_range(0, MAX_COLS - 1));
    return COL_W'($urandom_range(0, scr_cols - 1));
  endfunction

  function automatic logic [5:0] pick_row();
    if (scr_rows == 0 || $urandom_range(0, 4) == 0)
      return ROW_W'($urandom_range(0, MAX_ROWS - 1));
    return ROW_W'($urandom_range(0, scr_rows - 1));
  endfunction

  function automatic logic [7:0] pick_control();
    case ($urandom_range(0, 5))
      0:       return CH_NUL;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CHAR_W'($urandom_range(8'h20, 8'h7E));
    if (r < 85) return pick_control();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // One chunk of console traffic. Text lines dominate so the cursor wraps and
  // scrolls; positioned writes, clears and reads check the store behind it.
  task automatic random_burst();
    int         pick;
    int         len;
    logic [7:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      len = $urandom_range(1, 12);
      repeat (len) begin
        ch = ($urandom_range(0, 9) == 0) ? pick_char()
                                         : CHAR_W'($urandom_range(8'h20, 8'h7E));
        send_item(MODE_PUT_CURSOR, ch, pick_col(), pick_row());
      end
      ch = $urandom_range(0, 1) ? CH_LF : pick_control();
      send_item(MODE_PUT_CURSOR, ch, pick_col(), pick_row());
    end else if (pick < 60) begin
      send_item(MODE_PUT_AT, pick_char(), pick_col(), pick_row());
    end else if (pick < 70) begin
      // clears: mostly valid rows, the rest anywhere including past the bottom
      if (scr_rows > 0 && $urandom_range(0, 9) < 7)
        send_item(MODE_CLEAR_ROW, pick_char(), pick_col(),
                  ROW_W'($urandom_range(0, scr_rows - 1)));
      else
        send_item(MODE_CLEAR_ROW, pick_char(), pick_col(),
                  ROW_W'($urandom_range(0, MAX_ROWS - 1)));
    end else if (pick < 95) begin
      send_item(MODE_READ, pick_char(), pick_col(), pick_row());
    end else begin
      send_item(mode_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                COL_W'($urandom_range(0, MAX_COLS - 1)),
                ROW_W'($urandom_range(0, MAX_ROWS - 1)));
    end
  endtask

  initial begin
    int  target;
    int  new_cols;
    int  new_rows;
    bit  mid_drain_done;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SCREEN_COLS;
    cfg_data       = '0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    holds_asked    = 0;
    items_sent     = 0;
    mid_drain_done = 1'b0;
    scr_cols       = int'(RESET_COLS);
    scr_rows       = int'(RESET_ROWS);
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed, at the reset size of 80 x 25
    send_item(MODE_PUT_CURSOR, 8'h41, 7'd0, 6'd0);
    send_item(MODE_PUT_CURSOR, CH_NUL, 7'd0, 6'd0);       // cursor stays put
    send_item(MODE_PUT_CURSOR, CH_TAB, 7'd127, 6'd63);
    send_item(MODE_PUT_CURSOR, 8'hFF, 7'd0, 6'd0);
    send_item(MODE_PUT_CURSOR, CH_LF, 7'd0, 6'd0);
    send_item(MODE_PUT_CURSOR, CH_VT, 7'd0, 6'd0);
    send_item(MODE_PUT_CURSOR, CH_FF, 7'd0, 6'd0);
    send_item(MODE_PUT_CURSOR, 8'h80, 7'd0, 6'd0);
    send_item(MODE_PUT_CURSOR, CH_CR, 7'd0, 6'd0);
    send_item(MODE_PUT_AT, 8'h7E, 7'd127, 6'd63);         // outside the visible area
    send_item(MODE_PUT_AT, CH_LF, 7'd5, 6'd5);            // control: nothing stored
    send_item(MODE_PUT_AT, 8'h01, 7'd0, 6'd24);
    send_item(MODE_READ, 8'h00, 7'd127, 6'd63);
    send_item(MODE_READ, 8'hFF, 7'd0, 6'd0);
    send_item(MODE_READ, 8'h00, 7'd0, 6'd24);
    send_item(MODE_CLEAR_ROW, 8'h00, 7'd0, 6'd0);
    send_item(MODE_CLEAR_ROW, 8'h00, 7'd0, 6'd24);        // last visible row
    send_item(MODE_CLEAR_ROW, 8'h00, 7'd0, 6'd25);        // first row past the bottom
    send_item(MODE_CLEAR_ROW, 8'h00, 7'd0, 6'd63);
    send_item(MODE_READ, 8'h00, 7'd0, 6'd0);
    send_item(MODE_READ, 8'h00, 7'd1, 6'd0);
    send_item(MODE_READ, 8'h00, 7'd0, 6'd24);
    wait_console_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin new_cols = 127; new_rows = 63;  end
        1: begin new_cols = 1;   new_rows = 63;  end  // cursor marches down quickly
        2: begin new_cols = 127; new_rows = 1;   end  // next advance scrolls a lot
        3: begin new_cols = 0;   new_rows = 6;   end
        4: begin new_cols = 20;  new_rows = 0;   end
        5: begin new_cols = 0;   new_rows = 0;   end
        6: begin new_cols = 16;  new_rows = 127; end  // top data bit dropped by rows
        9: begin new_cols = int'(RESET_COLS); new_rows = int'(RESET_ROWS); end
        default: begin
          new_cols = $urandom_range(0, 127);
          new_rows = $urandom_range(0, 127);
        end
      endcase
      write_size(CFG_SCREEN_COLS, CFG_W'(new_cols));
      write_size(CFG_SCREEN_ROWS, CFG_W'(new_rows));

      // some phases run flat out on one side or both
      tx_idle = (phase % 3 != 2);
      rx_idle = (phase % 4 != 1);
      if (phase == 2) holds_asked++;

      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        random_burst();
        // sender pause mid-phase until the block has emptied
        if (phase == 7 && !mid_drain_done && items_sent >= target - 40) begin
          wait_console_idle();
          mid_drain_done = 1'b1;
        end
      end
      wait_console_idle();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: text_console_cell_writer.f
+incdir+rtl
rtl/tccw_pkg.sv
rtl/tccw_store.sv
rtl/text_console_cell_writer.sv
sim/tccw_result_checker.sv
sim/tb_text_console_cell_writer.sv
